/* rtl/core/gbe_pkg.sv */
// Shared types, constants and colour conversion for the glyph bitmap expander.
`default_nettype none

package gbe_pkg;

    localparam int HRES_DEF       = 320;
    localparam int VRES_DEF       = 240;
    localparam int PIXEL_BITS_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int BYTE_W   = 8;
    localparam int PIDX_W   = 17;
    localparam int RLEN_W   = 4;
    localparam int COLOUR_W = 16;
    localparam int RGB_W    = 24;
    localparam int ORG_W    = 11;
    localparam int DIM_W    = 7;
    localparam int SCALE_W  = 4;
    localparam int TOTAL_W  = 13;

    localparam logic [DIM_W-1:0]   GLYPH_MAX = 7'd64;
    localparam logic [SCALE_W-1:0] SCALE_MAX = 4'd8;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FG_COLOUR    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BG_COLOUR    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BG_ENABLE    = 3'd7;

    localparam logic [ORG_W-1:0]   RST_ORIGIN    = 11'd0;
    localparam logic [DIM_W-1:0]   RST_DIM       = 7'd8;
    localparam logic [SCALE_W-1:0] RST_SCALE     = 4'd1;
    localparam logic [RGB_W-1:0]   RST_FG_COLOUR = 24'hffffff;
    localparam logic [RGB_W-1:0]   RST_BG_COLOUR = 24'h000000;

    localparam logic [RGB_W-1:0] MASK_BLUE  = 24'h0000f8;
    localparam logic [RGB_W-1:0] MASK_GREEN = 24'h00f800;
    localparam logic [RGB_W-1:0] MASK_RED   = 24'hf80000;

    typedef struct packed {
        logic load;
        logic line;
        logic next_line;
        logic next_bit;
        logic flush;
    } gbe_cmd_t;

    typedef struct packed {
        logic total_zero;
        logic paints;
        logic line_last;
        logic byte_last;
        logic pend_valid;
        logic out_free;
    } gbe_stat_t;

    function automatic logic [COLOUR_W-1:0] convert_colour(input logic [RGB_W-1:0] c,
                                                          input logic rgb555);
        logic [RGB_W-1:0] packed555;
        logic [RGB_W-1:0] packed332;
        packed555 = ((c & MASK_BLUE) >> 3) | ((c & MASK_GREEN) >> 6) | ((c & MASK_RED) >> 9);
        packed332 = {16'd0, c[23:21], c[15:13], c[7:6]};
        if (rgb555)
            return packed555[COLOUR_W-1:0];
        else
            return packed332[COLOUR_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/gbe_if.sv */
// Stream interfaces for bitmap bytes in and pixel runs out.
`default_nettype none

interface gbe_byte_if;
    logic                      valid;
    logic                      ready;
    logic [gbe_pkg::BYTE_W-1:0] bitmap_byte;

    modport source (output valid, output bitmap_byte, input ready);
    modport sink   (input valid, input bitmap_byte, output ready);
endinterface

interface gbe_run_if;
    logic                         valid;
    logic                         ready;
    logic [gbe_pkg::PIDX_W-1:0]   pixel_index;
    logic [gbe_pkg::RLEN_W-1:0]   run_length;
    logic [gbe_pkg::COLOUR_W-1:0] pixel_colour;
    logic                         last;

    modport source (output valid, output pixel_index, output run_length,
                    output pixel_colour, output last, input ready);
    modport sink   (input valid, input pixel_index, input run_length,
                    input pixel_colour, input last, output ready);
endinterface

`default_nettype wire

/* rtl/core/gbe_ctrl.sv */
// Sequencing state machine: walks the bits of one byte and the scaled lines of each bit.
`default_nettype none

module gbe_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire gbe_pkg::gbe_stat_t stat,
    output gbe_pkg::gbe_cmd_t       cmd
);
    import gbe_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_STEP  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       step_ok;
    logic       bit_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // A line may only be captured when the pending run has somewhere to go.
    assign step_ok = !stat.pend_valid || stat.out_free;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        bit_go     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (!stat.total_zero)
                        state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (step_ok)
                begin
                    if (stat.paints)
                    begin
                        cmd.line = 1'b1;
                        if (stat.line_last)
                            bit_go = 1'b1;
                        else
                            cmd.next_line = 1'b1;
                    end
                    else
                    begin
                        bit_go = 1'b1;
                    end
                    cmd.next_bit = bit_go;
                    if (bit_go && stat.byte_last)
                        state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!stat.pend_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/gbe_datapath.sv */
// Glyph counters, run geometry, clipping, colour conversion and the run output registers.
`default_nettype none

module gbe_datapath #(
    parameter int HRES       = gbe_pkg::HRES_DEF,
    parameter int VRES       = gbe_pkg::VRES_DEF,
    parameter int PIXEL_BITS = gbe_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [gbe_pkg::ORG_W-1:0]    origin_x,
    input  wire logic [gbe_pkg::ORG_W-1:0]    origin_y,
    input  wire logic [gbe_pkg::DIM_W-1:0]    w,
    input  wire logic [gbe_pkg::DIM_W-1:0]    h,
    input  wire logic [gbe_pkg::SCALE_W-1:0]  s,
    input  wire logic [gbe_pkg::RGB_W-1:0]    fg_colour,
    input  wire logic [gbe_pkg::RGB_W-1:0]    bg_colour,
    input  wire logic                         bg_enable,
    input  wire logic                         cfg_clear,
    input  wire logic [gbe_pkg::BYTE_W-1:0]   bitmap_byte,
    input  wire gbe_pkg::gbe_cmd_t            cmd,
    output gbe_pkg::gbe_stat_t                stat,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [gbe_pkg::PIDX_W-1:0]        pixel_index,
    output logic [gbe_pkg::RLEN_W-1:0]        run_length,
    output logic [gbe_pkg::COLOUR_W-1:0]      pixel_colour,
    output logic                              last
);
    import gbe_pkg::*;

    localparam int CW  = 13;
    localparam int OFW = 9;
    localparam int XW  = $clog2(HRES);
    localparam int YW  = $clog2(VRES);
    localparam logic signed [CW-1:0] HMAX  = CW'(HRES - 1);
    localparam logic signed [CW-1:0] VLIM  = CW'(VRES);
    localparam logic [PIDX_W-1:0]    HMULT = PIDX_W'(HRES);
    localparam logic                 RGB555 = (PIXEL_BITS >= 16);

    logic [BYTE_W-1:0]  byte_reg;
    logic [2:0]         t_reg;
    logic [2:0]         j_reg;
    logic [11:0]        bc_reg;
    logic [5:0]         col_reg;
    logic [5:0]         row_reg;
    logic [OFW-1:0]     x_off_reg;
    logic [OFW-1:0]     y_off_reg;
    logic [TOTAL_W-1:0] total_reg;

    logic                pend_valid_reg;
    logic [PIDX_W-1:0]   pend_pidx_reg;
    logic [RLEN_W-1:0]   pend_rlen_reg;
    logic [COLOUR_W-1:0] pend_colour_reg;

    logic                out_valid_reg;
    logic [PIDX_W-1:0]   out_pidx_reg;
    logic [RLEN_W-1:0]   out_rlen_reg;
    logic [COLOUR_W-1:0] out_colour_reg;
    logic                out_last_reg;

    logic [2:0]            pos;
    logic                  bit_set;
    logic signed [CW-1:0]  ox;
    logic signed [CW-1:0]  oy;
    logic signed [CW-1:0]  xs_raw;
    logic signed [CW-1:0]  xe_raw;
    logic signed [CW-1:0]  xs_clip;
    logic signed [CW-1:0]  xe_clip;
    logic signed [CW-1:0]  y_line;
    logic signed [CW-1:0]  run_span;
    logic                  width_ok;
    logic                  y_in;
    logic                  glyph_last;
    logic                  col_wrap;
    logic                  capture;
    logic                  push;
    logic                  out_free;
    logic [PIDX_W-1:0]     cand_pidx;
    logic [COLOUR_W-1:0]   cand_colour;

    // The bit order within a byte runs downwards from the end of the glyph.
    assign pos     = 3'(total_reg[2:0] - bc_reg[2:0] - 3'd1);
    assign bit_set = byte_reg[pos];

    assign ox = {{(CW-ORG_W){origin_x[ORG_W-1]}}, origin_x};
    assign oy = {{(CW-ORG_W){origin_y[ORG_W-1]}}, origin_y};

    always_comb
    begin
        xs_raw   = ox + $signed({{(CW-OFW){1'b0}}, x_off_reg});
        xe_raw   = xs_raw + $signed({{(CW-SCALE_W){1'b0}}, s}) - $signed(CW'(1));
        xs_clip  = xs_raw[CW-1] ? '0 : xs_raw;
        xe_clip  = (xe_raw > HMAX) ? HMAX : xe_raw;
        width_ok = (s != '0) && (xe_clip >= xs_clip);
        run_span = xe_clip - xs_clip + $signed(CW'(1));
        y_line   = oy + $signed({{(CW-OFW){1'b0}}, y_off_reg})
                      + $signed({{(CW-3){1'b0}}, j_reg});
        y_in     = !y_line[CW-1] && (y_line < VLIM);
    end

    assign cand_pidx   = PIDX_W'(y_line[YW-1:0]) * HMULT + PIDX_W'(xs_clip[XW-1:0]);
    assign cand_colour = convert_colour(bit_set ? fg_colour : bg_colour, RGB555);

    assign glyph_last = (TOTAL_W'(bc_reg) + TOTAL_W'(1)) == total_reg;
    assign col_wrap   = (DIM_W'(col_reg) + DIM_W'(1)) == w;

    assign out_free = !out_valid_reg || out_ready;
    assign capture  = cmd.line && y_in;
    assign push     = (capture && pend_valid_reg) || cmd.flush;

    always_comb
    begin
        // Taken from the live dimensions so that a byte straight after a write sees them.
        stat.total_zero = (w == '0) || (h == '0);
        stat.paints     = (bit_set || bg_enable) && width_ok;
        stat.line_last  = ({1'b0, j_reg} == SCALE_W'(s - SCALE_W'(1)));
        stat.byte_last  = (t_reg == 3'd7) || glyph_last;
        stat.pend_valid = pend_valid_reg;
        stat.out_free   = out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg      <= TOTAL_W'(64);
            bc_reg         <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            x_off_reg      <= '0;
            y_off_reg      <= '0;
            t_reg          <= '0;
            j_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            total_reg <= TOTAL_W'(w) * TOTAL_W'(h);

            if (cfg_clear || (cmd.next_bit && glyph_last))
            begin
                bc_reg    <= '0;
                col_reg   <= '0;
                row_reg   <= '0;
                x_off_reg <= '0;
                y_off_reg <= '0;
            end
            else if (cmd.next_bit)
            begin
                bc_reg <= bc_reg + 12'd1;
                if (col_wrap)
                begin
                    col_reg   <= '0;
                    row_reg   <= row_reg + 6'd1;
                    x_off_reg <= '0;
                    y_off_reg <= OFW'(y_off_reg + OFW'(s));
                end
                else
                begin
                    col_reg   <= col_reg + 6'd1;
                    x_off_reg <= OFW'(x_off_reg + OFW'(s));
                end
            end

            if (cmd.load)
            begin
                t_reg <= '0;
                j_reg <= '0;
            end
            else if (cmd.next_bit)
            begin
                t_reg <= t_reg + 3'd1;
                j_reg <= '0;
            end
            else if (cmd.next_line)
            begin
                j_reg <= j_reg + 3'd1;
            end

            if (capture)
                pend_valid_reg <= 1'b1;
            else if (cmd.flush)
                pend_valid_reg <= 1'b0;

            if (push)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // One run is held back so that the final run of a byte can be marked.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            byte_reg <= bitmap_byte;
        if (capture)
        begin
            pend_pidx_reg   <= cand_pidx;
            pend_rlen_reg   <= RLEN_W'(run_span);
            pend_colour_reg <= cand_colour;
        end
        if (push)
        begin
            out_pidx_reg   <= pend_pidx_reg;
            out_rlen_reg   <= pend_rlen_reg;
            out_colour_reg <= pend_colour_reg;
            out_last_reg   <= cmd.flush;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_index  = out_pidx_reg;
    assign run_length   = out_rlen_reg;
    assign pixel_colour = out_colour_reg;
    assign last         = out_last_reg;

endmodule

`default_nettype wire

/* rtl/core/glyph_bitmap_expander.sv */
// Top level: configuration registers, sequencer and datapath of the glyph bitmap expander.
// A byte is taken when the block is idle; a bit that paints nothing or is clipped sideways is passed
// over, else its scaled lines are walked, one per unit of scale, one run per cycle for each line on screen.
// A byte passes through accept, bit walk and final run release.
// A held output word stalls the walk.
// Reset loads the register defaults, clears the glyph counters and empties both word stages.
`default_nettype none

module glyph_bitmap_expander #(
    parameter int HRES       = gbe_pkg::HRES_DEF,
    parameter int VRES       = gbe_pkg::VRES_DEF,
    parameter int PIXEL_BITS = gbe_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [gbe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [gbe_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    gbe_byte_if.sink                             in_byte,
    gbe_run_if.source                            out_run
);
    import gbe_pkg::*;

    logic [ORG_W-1:0]   origin_x_reg;
    logic [ORG_W-1:0]   origin_y_reg;
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [RGB_W-1:0]   fg_colour_reg;
    logic [RGB_W-1:0]   bg_colour_reg;
    logic               bg_enable_reg;

    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
    logic [SCALE_W-1:0] s;
    logic               in_ready;
    gbe_cmd_t           cmd;
    gbe_stat_t          stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg  <= RST_ORIGIN;
            origin_y_reg  <= RST_ORIGIN;
            width_reg     <= RST_DIM;
            height_reg    <= RST_DIM;
            scale_reg     <= RST_SCALE;
            fg_colour_reg <= RST_FG_COLOUR;
            bg_colour_reg <= RST_BG_COLOUR;
            bg_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ORIGIN_X:     origin_x_reg  <= cfg_wdata[ORG_W-1:0];
                REG_ORIGIN_Y:     origin_y_reg  <= cfg_wdata[ORG_W-1:0];
                REG_GLYPH_WIDTH:  width_reg     <= cfg_wdata[DIM_W-1:0];
                REG_GLYPH_HEIGHT: height_reg    <= cfg_wdata[DIM_W-1:0];
                REG_SCALE:        scale_reg     <= cfg_wdata[SCALE_W-1:0];
                REG_FG_COLOUR:    fg_colour_reg <= cfg_wdata[RGB_W-1:0];
                REG_BG_COLOUR:    bg_colour_reg <= cfg_wdata[RGB_W-1:0];
                REG_BG_ENABLE:    bg_enable_reg <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    // Oversized dimensions and scale saturate rather than wrap.
    assign w = (width_reg > GLYPH_MAX) ? GLYPH_MAX : width_reg;
    assign h = (height_reg > GLYPH_MAX) ? GLYPH_MAX : height_reg;
    assign s = (scale_reg > SCALE_MAX) ? SCALE_MAX : scale_reg;

    gbe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_byte.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gbe_datapath #(
        .HRES       (HRES),
        .VRES       (VRES),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .origin_x     (origin_x_reg),
        .origin_y     (origin_y_reg),
        .w            (w),
        .h            (h),
        .s            (s),
        .fg_colour    (fg_colour_reg),
        .bg_colour    (bg_colour_reg),
        .bg_enable    (bg_enable_reg),
        .cfg_clear    (cfg_we),
        .bitmap_byte  (in_byte.bitmap_byte),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (out_run.valid),
        .out_ready    (out_run.ready),
        .pixel_index  (out_run.pixel_index),
        .run_length   (out_run.run_length),
        .pixel_colour (out_run.pixel_colour),
        .last         (out_run.last)
    );

    assign in_byte.ready = in_ready;

endmodule

`default_nettype wire

/* rtl/core/gbe_checker.sv */
// Port-level checks on the run output of the glyph bitmap expander, bound to the top level.
`default_nettype none

module gbe_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            out_valid,
    input wire logic                            out_ready,
    input wire logic [gbe_pkg::PIDX_W-1:0]      pixel_index,
    input wire logic [gbe_pkg::RLEN_W-1:0]      run_length,
    input wire logic [gbe_pkg::COLOUR_W-1:0]    pixel_colour,
    input wire logic                            last
);
    import gbe_pkg::*;

    // Reset has emptied the output stage by the following edge.
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("output word present during reset");

    // A clipped run still covers one to eight pixels.
    a_run_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (run_length != 4'd0) && (run_length <= 4'd8))
        else $error("run length out of range");

    // Neither colour format uses the top bit.
    a_colour_top: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !pixel_colour[COLOUR_W-1])
        else $error("converted colour sets its top bit");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_index)
            && $stable(run_length) && $stable(pixel_colour) && $stable(last))
        else $error("stalled output word changed");

endmodule

bind glyph_bitmap_expander gbe_checker u_gbe_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_run.valid),
    .out_ready    (out_run.ready),
    .pixel_index  (out_run.pixel_index),
    .run_length   (out_run.run_length),
    .pixel_colour (out_run.pixel_colour),
    .last         (out_run.last)
);

`default_nettype wire
